// ===== rtl/edf_pkg.sv =====
package edf_pkg;

	// Number of task slots held in the cell chain
	localparam int NUM_TASKS = 16;

	// Field widths of the request and response items
	localparam int TASK_W = 4;
	localparam int EXEC_W = 16;
	localparam int TIME_W = 32;
	localparam int MASK_W = 16;

	// Width of a slot number inside the chain
	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// Common width for matching a request's slot against a cell's slot number
	localparam int CMP_W = (IDX_W > TASK_W) ? IDX_W : TASK_W;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic              command;
		logic [TASK_W-1:0] task_index;
		logic [EXEC_W-1:0] exec_time;
		logic [EXEC_W-1:0] period_ticks;
	} req_t;

	typedef struct packed {
		logic              running_valid;
		logic [TASK_W-1:0] running_task;
		logic [TIME_W-1:0] running_deadline;
		logic [MASK_W-1:0] missed_mask;
		logic [TIME_W-1:0] tick_time;
	} rsp_t;

	// Best candidate handed from cell to cell during a scan
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] gap;
		logic [TIME_W-1:0] deadline;
	} cand_t;

	// Sequencer strobes broadcast to the cells and the top level
	typedef struct packed {
		logic load_we;
		logic tick_start;
		logic scan_go;
		logic finish;
		logic finish_tick;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/edf_task_scheduler_unit.sv =====
// Earliest-deadline-first scheduler for up to NUM_TASKS periodic tasks. Each
// request either loads one slot (execution time and period, period zero
// disables it) or advances time by one tick; every request returns exactly
// one response. Slots live in a chain of cells, and the chain length sets the
// tick latency. On a tick, due jobs are released in all cells at the
// accepting edge; the sequencer then registers the scan launch, the best
// candidate walks down the cell chain through each cell's register, the scan
// token reaches the sequencer, and, once the response register is free, the
// winner is charged, time advances and the response is registered. A load's
// response is registered once the response register is free. One request is
// in flight at a time; the next one is accepted in the cycle after the
// response is registered, even while that response still waits to be taken.
// A response that is not taken holds the following one back until it is.
// Ties on deadline go to the lowest slot; deadlines compare by distance from
// the current time, so ordering survives wrap of the 32-bit clock.
module edf_task_scheduler_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  edf_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output edf_pkg::rsp_t  rsp_data
);

	localparam int N = edf_pkg::NUM_TASKS;

	edf_pkg::ctl_t              ctl;
	logic [edf_pkg::TIME_W-1:0] now_q;
	logic                       rsp_valid_q;
	edf_pkg::rsp_t              rsp_q;
	logic                       rsp_free;

	logic                       go_link   [N+1];
	edf_pkg::cand_t             cand_link [N+1];
	logic [N-1:0]               miss_vec;
	logic [N-1:0]               grant_vec;
	logic [edf_pkg::MASK_W-1:0] missed;
	edf_pkg::cand_t             fin;

	assign rsp_free = !rsp_valid_q || rsp_ready;

	edf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req_data.command),
		.scan_done   (go_link[N]),
		.rsp_free    (rsp_free),
		.req_ready   (req_ready),
		.ctl         (ctl)
	);

	// Feed the head of the chain with an empty candidate
	assign go_link[0]   = ctl.scan_go;
	assign cand_link[0] = '0;
	assign fin          = cand_link[N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			assign grant_vec[i] = ctl.finish_tick && fin.valid &&
				(fin.idx == edf_pkg::IDX_W'(i));

			edf_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.req      (req_data),
				.slot_id  (edf_pkg::IDX_W'(i)),
				.now      (now_q),
				.grant    (grant_vec[i]),
				.go_in    (go_link[i]),
				.cand_in  (cand_link[i]),
				.go_out   (go_link[i+1]),
				.cand_out (cand_link[i+1]),
				.miss     (miss_vec[i])
			);
		end

		// Only the first sixteen slots report misses
		for (i = 0; i < edf_pkg::MASK_W; i++) begin : g_miss
			if (i < N) begin : g_has
				assign missed[i] = miss_vec[i];
			end else begin : g_none
				assign missed[i] = 1'b0;
			end
		end
	endgenerate

	// Advance time after each tick commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (ctl.finish_tick) begin
			now_q <= now_q + 1'b1;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q.tick_time <= now_q;
			if (ctl.finish_tick) begin
				rsp_q.running_valid    <= fin.valid;
				rsp_q.running_task     <= fin.valid ?
					edf_pkg::TASK_W'(fin.idx) : '0;
				rsp_q.running_deadline <= fin.valid ? fin.deadline : '0;
				rsp_q.missed_mask      <= missed;
			end else begin
				rsp_q.running_valid    <= 1'b0;
				rsp_q.running_task     <= '0;
				rsp_q.running_deadline <= '0;
				rsp_q.missed_mask      <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_time_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish_tick |=> (now_q == $past(now_q) + 1'b1))
		else $error("time did not advance by one on a tick");

	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vec))
		else $error("more than one slot charged in a tick");

	a_load_rsp_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && !ctl.finish_tick) |=>
			(!rsp_q.running_valid && (rsp_q.missed_mask == '0)))
		else $error("load response carries tick results");

endmodule

// ===== rtl/edf_cell.sv =====
module edf_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  edf_pkg::ctl_t                  ctl,
	input  edf_pkg::req_t                  req,
	input  logic [edf_pkg::IDX_W-1:0]      slot_id,
	input  logic [edf_pkg::TIME_W-1:0]     now,
	input  logic                           grant,
	input  logic                           go_in,
	input  edf_pkg::cand_t                 cand_in,
	output logic                           go_out,
	output edf_pkg::cand_t                 cand_out,
	output logic                           miss
);

	logic [edf_pkg::EXEC_W-1:0] exec_q;
	logic [edf_pkg::EXEC_W-1:0] period_q;
	logic [edf_pkg::EXEC_W-1:0] remain_q;
	logic [edf_pkg::TIME_W-1:0] deadline_q;
	logic [edf_pkg::EXEC_W-1:0] count_q;
	logic                       miss_q;
	logic                       go_q;
	edf_pkg::cand_t             cand_q;

	logic                       active;
	logic                       hit;
	logic                       rel;
	logic                       elig;
	logic                       take;
	logic [edf_pkg::TIME_W-1:0] own_dist;

	// Decode slot match, release and eligibility
	assign active   = (period_q != '0);
	assign hit      = (edf_pkg::CMP_W'(req.task_index) == edf_pkg::CMP_W'(slot_id));
	assign rel      = active && (count_q == '0);
	assign elig     = active && (remain_q != '0);
	assign own_dist = deadline_q - now;
	assign take     = elig && (!cand_in.valid || (own_dist < cand_in.gap));

	// Load a slot, release its job on a tick, or burn one tick of work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q     <= '0;
			period_q   <= '0;
			remain_q   <= '0;
			deadline_q <= '0;
			count_q    <= '0;
		end else if (ctl.load_we && hit) begin
			exec_q   <= req.exec_time;
			period_q <= req.period_ticks;
			if (req.period_ticks != '0) begin
				remain_q   <= req.exec_time;
				deadline_q <= now + edf_pkg::TIME_W'(req.period_ticks);
				count_q    <= req.period_ticks;
			end else begin
				remain_q   <= '0;
				deadline_q <= '0;
				count_q    <= '0;
			end
		end else if (ctl.tick_start && active) begin
			// the countdown step of the tick is folded in here
			if (rel) begin
				remain_q   <= exec_q;
				deadline_q <= now + edf_pkg::TIME_W'(period_q);
				count_q    <= period_q - 1'b1;
			end else begin
				count_q <= count_q - 1'b1;
			end
		end else if (grant) begin
			remain_q <= remain_q - 1'b1;
		end
	end

	// Flag a miss when a job is replaced with work left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= 1'b0;
		end else if (ctl.tick_start) begin
			miss_q <= rel && (remain_q != '0);
		end
	end

	// Pass the scan token along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= go_in;
		end
	end

	// Keep the earlier candidate unless this slot is strictly earlier
	always_ff @(posedge clk) begin
		if (go_in) begin
			if (take) begin
				cand_q.valid    <= 1'b1;
				cand_q.idx      <= slot_id;
				cand_q.gap      <= own_dist;
				cand_q.deadline <= deadline_q;
			end else begin
				cand_q <= cand_in;
			end
		end
	end

	assign go_out   = go_q;
	assign cand_out = cand_q;
	assign miss     = miss_q;

	a_grant_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		grant |-> (remain_q != '0) && active)
		else $error("grant to a slot with no pending work");

endmodule

// ===== rtl/edf_ctrl.sv =====
module edf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_command,
	input  logic           scan_done,
	input  logic           rsp_free,
	output logic           req_ready,
	output edf_pkg::ctl_t  ctl
);

	edf_pkg::state_t state_q;
	edf_pkg::state_t state_d;
	logic            tick_q;
	logic            scan_go_q;
	logic            accept;

	assign accept = req_valid && req_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			edf_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_command == edf_pkg::CMD_TICK) ?
						edf_pkg::ST_SCAN : edf_pkg::ST_FINISH;
				end
			end
			edf_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = edf_pkg::ST_FINISH;
				end
			end
			edf_pkg::ST_FINISH: begin
				if (rsp_free) begin
					state_d = edf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = edf_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready       = 1'b0;
		ctl.load_we     = 1'b0;
		ctl.tick_start  = 1'b0;
		ctl.scan_go     = scan_go_q;
		ctl.finish      = 1'b0;
		ctl.finish_tick = 1'b0;
		unique case (state_q)
			edf_pkg::ST_IDLE: begin
				req_ready      = 1'b1;
				ctl.load_we    = req_valid && (req_command == edf_pkg::CMD_LOAD);
				ctl.tick_start = req_valid && (req_command == edf_pkg::CMD_TICK);
			end
			edf_pkg::ST_SCAN: begin
			end
			edf_pkg::ST_FINISH: begin
				ctl.finish      = rsp_free;
				ctl.finish_tick = rsp_free && tick_q;
			end
			default: begin
			end
		endcase
	end

	// Hold state, command kind and scan launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= edf_pkg::ST_IDLE;
			tick_q    <= 1'b0;
			scan_go_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_go_q <= ctl.tick_start;
			if (accept) begin
				tick_q <= (req_command == edf_pkg::CMD_TICK);
			end
		end
	end

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == edf_pkg::ST_SCAN))
		else $error("scan token left the chain outside a scan");

	a_strobes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load_we, ctl.tick_start, ctl.scan_go, ctl.finish}))
		else $error("sequencer strobes overlap");

endmodule
